@@ sv/segment_triangle_intersect_unit_assert.svh @@
// Assertion macros used by the segment/triangle intersection checker.
`ifndef SEGMENT_TRIANGLE_INTERSECT_UNIT_ASSERT_SVH
`define SEGMENT_TRIANGLE_INTERSECT_UNIT_ASSERT_SVH

// Implication checked in the same cycle, disabled while reset is held.
`define STI_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("segment/triangle check failed");

// Implication checked in the following cycle, disabled while reset is held.
`define STI_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("segment/triangle check failed");

// Implication checked in the following cycle, also evaluated during reset.
`define STI_ASSERT_NEXT_RST(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) (ante) |=> (cons)) \
        else $error("segment/triangle reset check failed");

`endif

@@ sv/sti_pkg.sv @@
// Package with widths, register codes and arithmetic helpers of the intersection unit.
package sti_pkg;

    localparam int COORD_BITS    = 16;
    localparam int FRACTION_BITS = 16;

    // Differences of two coordinates, cross products, dot terms, dot sums.
    localparam int DIFF_W = COORD_BITS + 1;
    localparam int CROSS_W = 2 * DIFF_W + 1;
    localparam int PROD_W = DIFF_W + CROSS_W;
    localparam int SUM_W = PROD_W + 3;
    localparam int REM_W = SUM_W;
    localparam int QUO_W = FRACTION_BITS + 1;

    // Configuration register indexes.
    localparam int CFG_SEG_START_X = 0;
    localparam int CFG_SEG_START_Y = 1;
    localparam int CFG_SEG_START_Z = 2;
    localparam int CFG_SEG_END_X   = 3;
    localparam int CFG_SEG_END_Y   = 4;
    localparam int CFG_SEG_END_Z   = 5;
    localparam int CFG_NUM         = 6;
    localparam int CFG_IDX_W       = $clog2(CFG_NUM);
    localparam int ADDR_W          = CFG_IDX_W + 2;

    typedef logic signed [COORD_BITS-1:0] t_coord;
    typedef logic signed [DIFF_W-1:0]     t_diff;
    typedef logic signed [CROSS_W-1:0]    t_cross;
    typedef logic signed [PROD_W-1:0]     t_prod;
    typedef logic signed [SUM_W-1:0]      t_sum;
    typedef logic [REM_W-1:0]             t_rem;
    typedef logic [QUO_W-1:0]             t_quo;

    // One component of a cross product: a*b - c*e.
    function automatic t_cross cross_term(t_diff a, t_diff b, t_diff c, t_diff e);
        t_cross ea, eb, ec, ee;
        ea = CROSS_W'(a);
        eb = CROSS_W'(b);
        ec = CROSS_W'(c);
        ee = CROSS_W'(e);
        return ea * eb - ec * ee;
    endfunction

    // One term of a dot product.
    function automatic t_prod dot_term(t_diff a, t_cross b);
        t_prod ea, eb;
        ea = PROD_W'(a);
        eb = PROD_W'(b);
        return ea * eb;
    endfunction

endpackage

@@ sv/sti_if.sv @@
// Request channel interfaces for triangles in and intersection results out.
interface sti_tri_if;
    import sti_pkg::*;
    logic   valid;
    logic   ready;
    t_coord vertex_a_x;
    t_coord vertex_a_y;
    t_coord vertex_a_z;
    t_coord vertex_b_x;
    t_coord vertex_b_y;
    t_coord vertex_b_z;
    t_coord vertex_c_x;
    t_coord vertex_c_y;
    t_coord vertex_c_z;

    modport source (output valid, vertex_a_x, vertex_a_y, vertex_a_z, vertex_b_x,
                    vertex_b_y, vertex_b_z, vertex_c_x, vertex_c_y, vertex_c_z,
                    input ready);
    modport sink (input valid, vertex_a_x, vertex_a_y, vertex_a_z, vertex_b_x,
                  vertex_b_y, vertex_b_z, vertex_c_x, vertex_c_y, vertex_c_z,
                  output ready);
endinterface

interface sti_res_if;
    import sti_pkg::*;
    logic valid;
    logic ready;
    logic hit;
    t_quo hit_fraction;

    modport source (output valid, hit, hit_fraction, input ready);
    modport sink (input valid, hit, hit_fraction, output ready);
endinterface

@@ sv/segment_triangle_intersect_unit.sv @@
// Pipelined one-sided segment/triangle intersection unit with APB configuration.
//
// Usage: write the segment start and end points through the APB port while the
// unit is idle (register i at byte address 4*i, signed coordinates in the low
// bits of pwdata). Then stream triangles on i_tri; each accepted triangle
// request yields exactly one result request on o_res, in order, carrying hit
// and the hit fraction t/d as unsigned Q1.16 (1.0 reads as 65536, 0 on a miss).
//
// The request passes twenty-one register stages, the first of them loaded at the
// accepting edge; o_res.valid rises when the last one holds it. The stages are
// differences, cross products, dot terms and dot sums, one compare stage, and
// sixteen restoring division stages, one quotient bit per stage. The division
// chain sets the depth. Throughput is one triangle per cycle while the receiver
// does not stall.
//
// Each stage advances when it is empty or when the stage after it advances, so
// a stalled receiver holds the final result while bubbles further up the pipe
// keep filling; i_tri.ready drops only once every stage is occupied. Nothing is
// lost or repeated under a stall. Reset clears the segment registers to zero
// and empties the pipeline; pready is always high.
module segment_triangle_intersect_unit (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    sti_tri_if.sink                      i_tri,
    sti_res_if.source                    o_res,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [sti_pkg::ADDR_W-1:0]   paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready
);
    import sti_pkg::*;

    localparam int NS = 5 + FRACTION_BITS;
    localparam int DIV0 = 5;

    // Configuration registers and APB access.
    t_coord               r_cfg [CFG_NUM];
    logic [CFG_IDX_W-1:0] cfg_idx;

    assign cfg_idx = paddr[ADDR_W-1:2];
    assign pready  = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < CFG_NUM; i++) begin
                r_cfg[i] <= '0;
            end
        end else if (psel && penable && pwrite && (32'(cfg_idx) < CFG_NUM)) begin
            r_cfg[cfg_idx] <= pwdata[COORD_BITS-1:0];
        end
    end

    always_comb begin
        prdata = '0;
        if (32'(cfg_idx) < CFG_NUM) begin
            prdata = 32'(unsigned'(r_cfg[cfg_idx]));
        end
    end

    // The user keeps the segment stable while requests are in flight; the block
    // does not enforce it. Its direction P - Q is formed straight from the registers.
    t_diff seg_p [3];
    t_diff qp [3];
    always_comb begin
        seg_p[0] = DIFF_W'(r_cfg[CFG_SEG_START_X]);
        seg_p[1] = DIFF_W'(r_cfg[CFG_SEG_START_Y]);
        seg_p[2] = DIFF_W'(r_cfg[CFG_SEG_START_Z]);
        qp[0] = seg_p[0] - DIFF_W'(r_cfg[CFG_SEG_END_X]);
        qp[1] = seg_p[1] - DIFF_W'(r_cfg[CFG_SEG_END_Y]);
        qp[2] = seg_p[2] - DIFF_W'(r_cfg[CFG_SEG_END_Z]);
    end

    // Stage enables: a stage loads when it is empty or its successor moves on.
    logic [NS-1:0] r_vld;
    logic [NS-1:0] en;
    always_comb begin
        en[NS-1] = !r_vld[NS-1] || o_res.ready;
        for (int k = NS - 2; k >= 0; k--) begin
            en[k] = !r_vld[k] || en[k+1];
        end
    end

    assign i_tri.ready = en[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (en[0]) begin
                r_vld[0] <= i_tri.valid;
            end
            for (int k = 1; k < NS; k++) begin
                if (en[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    // Stage 0: triangle edges AB, AC and the offset P - A.
    t_diff va [3];
    t_diff vb [3];
    t_diff vc [3];
    t_diff r0_ab [3];
    t_diff r0_ac [3];
    t_diff r0_ap [3];
    always_comb begin
        va[0] = DIFF_W'(i_tri.vertex_a_x);
        va[1] = DIFF_W'(i_tri.vertex_a_y);
        va[2] = DIFF_W'(i_tri.vertex_a_z);
        vb[0] = DIFF_W'(i_tri.vertex_b_x);
        vb[1] = DIFF_W'(i_tri.vertex_b_y);
        vb[2] = DIFF_W'(i_tri.vertex_b_z);
        vc[0] = DIFF_W'(i_tri.vertex_c_x);
        vc[1] = DIFF_W'(i_tri.vertex_c_y);
        vc[2] = DIFF_W'(i_tri.vertex_c_z);
    end

    always_ff @(posedge i_clk) begin
        if (en[0]) begin
            for (int i = 0; i < 3; i++) begin
                r0_ab[i] <= vb[i] - va[i];
                r0_ac[i] <= vc[i] - va[i];
                r0_ap[i] <= seg_p[i] - va[i];
            end
        end
    end

    // Stage 1: normal N = AB x AC and E = (P - Q) x (P - A).
    t_cross r1_n [3];
    t_cross r1_e [3];
    t_diff  r1_ab [3];
    t_diff  r1_ac [3];
    t_diff  r1_ap [3];
    always_ff @(posedge i_clk) begin
        if (en[1]) begin
            r1_n[0] <= cross_term(r0_ab[1], r0_ac[2], r0_ab[2], r0_ac[1]);
            r1_n[1] <= cross_term(r0_ab[2], r0_ac[0], r0_ab[0], r0_ac[2]);
            r1_n[2] <= cross_term(r0_ab[0], r0_ac[1], r0_ab[1], r0_ac[0]);
            r1_e[0] <= cross_term(qp[1], r0_ap[2], qp[2], r0_ap[1]);
            r1_e[1] <= cross_term(qp[2], r0_ap[0], qp[0], r0_ap[2]);
            r1_e[2] <= cross_term(qp[0], r0_ap[1], qp[1], r0_ap[0]);
            r1_ab <= r0_ab;
            r1_ac <= r0_ac;
            r1_ap <= r0_ap;
        end
    end

    // Stage 2: the twelve dot product terms.
    t_prod r2_pd [3];
    t_prod r2_pt [3];
    t_prod r2_pv [3];
    t_prod r2_pw [3];
    always_ff @(posedge i_clk) begin
        if (en[2]) begin
            for (int i = 0; i < 3; i++) begin
                r2_pd[i] <= dot_term(qp[i], r1_n[i]);
                r2_pt[i] <= dot_term(r1_ap[i], r1_n[i]);
                r2_pv[i] <= dot_term(r1_ac[i], r1_e[i]);
                r2_pw[i] <= dot_term(r1_ab[i], r1_e[i]);
            end
        end
    end

    // Stage 3: d, t, v and w = -(AB . E).
    t_sum r3_d, r3_t, r3_v, r3_w;
    always_ff @(posedge i_clk) begin
        if (en[3]) begin
            r3_d <= SUM_W'(r2_pd[0]) + SUM_W'(r2_pd[1]) + SUM_W'(r2_pd[2]);
            r3_t <= SUM_W'(r2_pt[0]) + SUM_W'(r2_pt[1]) + SUM_W'(r2_pt[2]);
            r3_v <= SUM_W'(r2_pv[0]) + SUM_W'(r2_pv[1]) + SUM_W'(r2_pv[2]);
            r3_w <= -(SUM_W'(r2_pw[0]) + SUM_W'(r2_pw[1]) + SUM_W'(r2_pw[2]));
        end
    end

    // Stage 4: bounds test and the integer quotient bit, which is set only
    // when the hit lies exactly at the segment end (t equal to d).
    logic signed [SUM_W:0] vw_sum;
    logic                  bounds_ok;
    logic                  t_at_end;
    assign vw_sum    = (SUM_W+1)'(r3_v) + (SUM_W+1)'(r3_w);
    assign bounds_ok = (r3_d > 0) && (r3_t >= 0) && (r3_t <= r3_d)
                    && (r3_v >= 0) && (r3_v <= r3_d) && (r3_w >= 0)
                    && (vw_sum <= (SUM_W+1)'(r3_d));
    assign t_at_end  = (r3_t == r3_d);

    logic r4_hit;
    t_rem r4_rem;
    t_rem r4_d;
    t_quo r4_q;
    always_ff @(posedge i_clk) begin
        if (en[4]) begin
            r4_hit <= bounds_ok;
            r4_d   <= REM_W'(unsigned'(r3_d));
            r4_rem <= t_at_end ? '0 : REM_W'(unsigned'(r3_t));
            r4_q   <= t_at_end ? QUO_W'(1) : '0;
        end
    end

    // Stages 5 on: restoring division, one fraction bit per stage.
    logic r_hit [FRACTION_BITS];
    t_rem r_rem [FRACTION_BITS];
    t_rem r_d   [FRACTION_BITS];
    t_quo r_q   [FRACTION_BITS];
    logic s_hit [FRACTION_BITS];
    t_rem s_rem [FRACTION_BITS];
    t_rem s_d   [FRACTION_BITS];
    t_quo s_q   [FRACTION_BITS];
    t_rem rem2  [FRACTION_BITS];

    always_comb begin
        for (int k = 0; k < FRACTION_BITS; k++) begin
            if (k == 0) begin
                s_hit[k] = r4_hit;
                s_rem[k] = r4_rem;
                s_d[k]   = r4_d;
                s_q[k]   = r4_q;
            end else begin
                s_hit[k] = r_hit[k-1];
                s_rem[k] = r_rem[k-1];
                s_d[k]   = r_d[k-1];
                s_q[k]   = r_q[k-1];
            end
            rem2[k] = s_rem[k] << 1;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < FRACTION_BITS; k++) begin
            if (en[DIV0+k]) begin
                r_hit[k] <= s_hit[k];
                r_d[k]   <= s_d[k];
                if (rem2[k] >= s_d[k]) begin
                    r_rem[k] <= rem2[k] - s_d[k];
                    r_q[k]   <= {s_q[k][QUO_W-2:0], 1'b1};
                end else begin
                    r_rem[k] <= rem2[k];
                    r_q[k]   <= {s_q[k][QUO_W-2:0], 1'b0};
                end
            end
        end
    end

    // The last division stage is the output register.
    assign o_res.valid        = r_vld[NS-1];
    assign o_res.hit          = r_hit[FRACTION_BITS-1];
    assign o_res.hit_fraction = r_hit[FRACTION_BITS-1] ? r_q[FRACTION_BITS-1] : '0;

endmodule

@@ sv/sti_checker.sv @@
// Port-level checker for the intersection unit and its bind statement.
`include "segment_triangle_intersect_unit_assert.svh"

module sti_checker (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       i_out_valid,
    input logic                       i_out_ready,
    input logic                       i_out_hit,
    input logic [sti_pkg::QUO_W-1:0]  i_out_fraction
);
    import sti_pkg::*;

    localparam t_quo ONE = t_quo'(1) << FRACTION_BITS;

    // A result waiting on the receiver stays offered.
    `STI_ASSERT_NEXT(a_out_hold, i_out_valid && !i_out_ready, i_out_valid)
    // A miss never carries a fraction.
    `STI_ASSERT_IMPL(a_miss_zero, i_out_valid && !i_out_hit, i_out_fraction == '0)
    // A hit fraction never exceeds one.
    `STI_ASSERT_IMPL(a_frac_range, i_out_valid && i_out_hit, i_out_fraction <= ONE)
    // Reset empties the pipeline.
    `STI_ASSERT_NEXT_RST(a_reset_empty, !i_rst_n, !i_out_valid)

endmodule

bind segment_triangle_intersect_unit sti_checker u_sti_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_out_valid    (o_res.valid),
    .i_out_ready    (o_res.ready),
    .i_out_hit      (o_res.hit),
    .i_out_fraction (o_res.hit_fraction)
);
